// ===== rtl/core/htw_pkg.sv =====
// htw_pkg: shared types, constants and helpers of the huffman tree-walk decoder
// no dependencies; compiled before the interfaces and all modules
`default_nettype none

package htw_pkg;

	localparam int TREE_NODES = 512;
	localparam int ADDR_W     = $clog2(TREE_NODES);
	localparam int IDX_W      = 9;
	localparam int SYM_W      = 8;

	// result buffer
	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [SYM_W-1:0]     sym_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [OUT_CNT_W-1:0] out_cnt_t;

	typedef enum logic [1:0] {
		MODE_WRITE   = 2'd0,
		MODE_DECODE  = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef struct packed {
		idx_t left;
		idx_t right;
		sym_t sym;
	} node_t;

	typedef struct packed {
		logic symbol_valid;
		sym_t symbol;
		logic walk_error;
	} result_t;

	typedef struct packed {
		logic  wr_en;
		idx_t  wr_idx;
		node_t wr_node;
		logic  rd_en;
		idx_t  rd_idx;
		idx_t  root_idx;
	} store_req_t;

	typedef struct packed {
		node_t child;
		node_t root;
	} store_rsp_t;

	typedef struct packed {
		logic    push;
		result_t data;
	} push_t;

	function automatic logic in_store(idx_t i);
		return int'(i) < TREE_NODES;
	endfunction

	function automatic addr_t to_addr(idx_t i);
		return addr_t'(i);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/htw_if.sv =====
// htw_if: valid/ready channel interfaces for command items and result items
// depends on htw_pkg
`default_nettype none

interface htw_cmd_if;
	import htw_pkg::*;

	logic       valid;
	logic       ready;
	logic [1:0] mode;
	idx_t       node_index;
	idx_t       left_child;
	idx_t       right_child;
	sym_t       leaf_symbol;
	logic       code_bit;

	modport source (output valid, output mode, output node_index, output left_child,
		output right_child, output leaf_symbol, output code_bit, input ready);
	modport sink (input valid, input mode, input node_index, input left_child,
		input right_child, input leaf_symbol, input code_bit, output ready);
endinterface

interface htw_result_if;
	import htw_pkg::*;

	logic valid;
	logic ready;
	logic symbol_valid;
	sym_t symbol;
	logic walk_error;

	modport source (output valid, output symbol_valid, output symbol, output walk_error,
		input ready);
	modport sink (input valid, input symbol_valid, input symbol, input walk_error,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/htw_node_store.sv =====
// htw_node_store: node memory for child fetch plus a mirror that tracks the root entry
// depends on htw_pkg
`default_nettype none

module htw_node_store (
	input  logic                   clk,
	input  htw_pkg::store_req_t    req,
	output htw_pkg::store_rsp_t    rsp
);
	import htw_pkg::*;

	node_t mem_a [TREE_NODES];
	node_t mem_b [TREE_NODES];
	node_t a_q;
	node_t b_q;
	logic  a_ok_q;
	logic  b_ok_q;
	logic  wr_ok;
	logic  fwd;

	assign wr_ok = req.wr_en && in_store(req.wr_idx);
	// write to the root entry in the same cycle bypasses the mirror read
	assign fwd   = wr_ok && (req.wr_idx == req.root_idx);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_a[to_addr(req.wr_idx)] <= req.wr_node;
			mem_b[to_addr(req.wr_idx)] <= req.wr_node;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			a_q    <= mem_a[to_addr(req.rd_idx)];
			a_ok_q <= in_store(req.rd_idx);
		end
	end

	always_ff @(posedge clk) begin
		b_ok_q <= in_store(req.root_idx);
		if (fwd) begin
			b_q <= req.wr_node;
		end else begin
			b_q <= mem_b[to_addr(req.root_idx)];
		end
	end

	// entries beyond the store read as all zero
	assign rsp.child = a_ok_q ? a_q : '0;
	assign rsp.root  = b_ok_q ? b_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/htw_walk_ctrl.sv =====
// htw_walk_ctrl: command decode, walk state, child-fetch stage and result forming
// depends on htw_pkg and htw_if
`default_nettype none

module htw_walk_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	htw_cmd_if.sink             cmd,
	input  logic                cfg_wr_en,
	input  htw_pkg::idx_t       cfg_wr_data,
	output htw_pkg::store_req_t req,
	input  htw_pkg::store_rsp_t rsp,
	input  htw_pkg::out_cnt_t   fifo_cnt,
	output htw_pkg::push_t      push
);
	import htw_pkg::*;

	idx_t  root_q;
	logic  at_root_q;
	idx_t  cur_idx_q;
	node_t cur_ent_q;
	logic  bit_v_s1;
	logic  bit_err_s1;
	idx_t  next_idx_s1;

	logic  accept;
	logic  is_wr;
	logic  is_bit;
	logic  is_rst;
	logic  child_leaf;
	logic  res_root;
	idx_t  res_idx;
	node_t res_ent;
	node_t here_ent;
	logic  here_leaf;
	idx_t  next_idx;
	node_t wr_node;
	logic  at_root_d;
	idx_t  cur_idx_d;
	node_t cur_ent_d;

	assign cmd.ready = (fifo_cnt + out_cnt_t'(bit_v_s1)) < out_cnt_t'(OUT_DEPTH - 1);
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		is_wr  = 1'b0;
		is_bit = 1'b0;
		is_rst = 1'b0;
		unique case (cmd.mode)
			MODE_WRITE:   is_wr  = 1'b1;
			MODE_DECODE:  is_bit = 1'b1;
			MODE_RESTART: is_rst = 1'b1;
			default: ;
		endcase
	end

	assign child_leaf = rsp.child.sym != '0;

	// walk position once the bit in flight has landed
	always_comb begin
		res_root = at_root_q;
		res_idx  = cur_idx_q;
		res_ent  = cur_ent_q;
		if (bit_v_s1 && !bit_err_s1) begin
			if (child_leaf) begin
				res_root = 1'b1;
			end else begin
				res_root = 1'b0;
				res_idx  = next_idx_s1;
				res_ent  = rsp.child;
			end
		end
	end

	assign here_ent  = res_root ? rsp.root : res_ent;
	assign here_leaf = here_ent.sym != '0;
	assign next_idx  = cmd.code_bit ? here_ent.right : here_ent.left;
	assign wr_node   = '{left: cmd.left_child, right: cmd.right_child, sym: cmd.leaf_symbol};

	always_comb begin
		req.wr_en    = accept && is_wr;
		req.wr_idx   = cmd.node_index;
		req.wr_node  = wr_node;
		req.rd_en    = accept && is_bit && !here_leaf;
		req.rd_idx   = next_idx;
		req.root_idx = cfg_wr_en ? cfg_wr_data : root_q;
	end

	always_comb begin
		push.push = bit_v_s1;
		push.data = '0;
		if (bit_err_s1) begin
			push.data.walk_error = 1'b1;
		end else if (child_leaf) begin
			push.data.symbol_valid = 1'b1;
			push.data.symbol       = rsp.child.sym;
		end
	end

	always_comb begin
		at_root_d = res_root;
		cur_idx_d = res_idx;
		cur_ent_d = res_ent;
		// keep the held entry in step with writes to the node we stand on
		if (accept && is_wr && in_store(cmd.node_index) && (cmd.node_index == res_idx)) begin
			cur_ent_d = wr_node;
		end
		if (accept && is_rst) begin
			at_root_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q    <= '0;
			at_root_q <= 1'b1;
			cur_idx_q <= '0;
			bit_v_s1  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				root_q <= cfg_wr_data;
			end
			at_root_q <= at_root_d;
			cur_idx_q <= cur_idx_d;
			bit_v_s1  <= accept && is_bit;
		end
	end

	always_ff @(posedge clk) begin
		cur_ent_q   <= cur_ent_d;
		bit_err_s1  <= here_leaf;
		next_idx_s1 <= next_idx;
	end

	a_leaf_returns_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		bit_v_s1 && !bit_err_s1 && child_leaf |=> at_root_q)
		else $error("walk did not return to root after a leaf");

	a_fetch_feeds_stage: assert property (@(posedge clk) disable iff (!arst_n)
		req.rd_en |=> bit_v_s1 && !bit_err_s1)
		else $error("child fetch without a resolving bit");

	a_leaf_bit_errors: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_bit && here_leaf |=> bit_v_s1 && bit_err_s1)
		else $error("bit at a leaf not flagged");

endmodule

`default_nettype wire

// ===== rtl/core/htw_out_fifo.sv =====
// htw_out_fifo: small result buffer that decouples the walk from the result receiver
// depends on htw_pkg and htw_if
`default_nettype none

module htw_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  htw_pkg::push_t    push,
	output htw_pkg::out_cnt_t cnt,
	htw_result_if.source      result
);
	import htw_pkg::*;

	result_t              buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	out_cnt_t             cnt_q;
	logic                 pop;

	assign result.valid        = cnt_q != '0;
	assign result.symbol_valid = buf_q[rd_ptr_q].symbol_valid;
	assign result.symbol       = buf_q[rd_ptr_q].symbol;
	assign result.walk_error   = buf_q[rd_ptr_q].walk_error;
	assign pop                 = result.valid && result.ready;
	assign cnt                 = cnt_q;

	always_ff @(posedge clk) begin
		if (push.push) begin
			buf_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.push) begin
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			end
			case ({push.push, pop})
				2'b10:   cnt_q <= cnt_q + out_cnt_t'(1);
				2'b01:   cnt_q <= cnt_q - out_cnt_t'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.push && cnt_q == out_cnt_t'(OUT_DEPTH)))
		else $error("result buffer overflow");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push.push && !pop |=> cnt_q == $past(cnt_q) + out_cnt_t'(1))
		else $error("result count out of step");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		push.push && cnt_q == '0 |=> result.valid)
		else $error("pushed item not presented");

endmodule

`default_nettype wire

// ===== rtl/core/huffman_tree_walk_decoder.sv =====
// huffman_tree_walk_decoder: top level of the bit-serial huffman tree-walk decoder
// depends on htw_pkg, htw_if, htw_node_store, htw_walk_ctrl and htw_out_fifo
//
// usage
//   cmd carries one item per handshake: mode 0 writes a tree node (node_index,
//   left_child, right_child, leaf_symbol; symbol 0 marks an internal node),
//   mode 1 applies code_bit to the walk, mode 2 returns the walk to the root,
//   mode 3 is ignored. only decode items produce a result item on result:
//   symbol_valid/symbol when the bit completed a code, walk_error when the bit
//   hit a leaf (single-node tree). cfg_wr_en/cfg_wr_data set the root index,
//   written while the block is idle.
// timing
//   one item per cycle while cmd.ready is high. a decode result is registered in
//   the child-fetch stage, then queued in the result buffer; the stage is set by the
//   single node-store read per code bit, whose registered data steers the next bit's read address.
// reset
//   walk at the root, root index 0; node memory is not cleared and must be
//   loaded before decoding.
// stall
//   results queue in a four-deep buffer; cmd.ready drops once buffered plus
//   in-flight results reach three and returns as the receiver takes them.
`default_nettype none

module huffman_tree_walk_decoder (
	input  logic          clk,
	input  logic          arst_n,
	htw_cmd_if.sink       cmd,
	htw_result_if.source  result,
	input  logic          cfg_wr_en,
	input  htw_pkg::idx_t cfg_wr_data
);
	import htw_pkg::*;

	// store request and response between walk control and node memories
	store_req_t store_req;
	store_rsp_t store_rsp;

	// result push and buffer fill level
	push_t    res_push;
	out_cnt_t res_cnt;

	// node memory plus root mirror, registered read
	htw_node_store u_store (
		.clk (clk),
		.req (store_req),
		.rsp (store_rsp)
	);

	// decode, walk state and the child-fetch stage
	htw_walk_ctrl u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (store_req),
		.rsp         (store_rsp),
		.fifo_cnt    (res_cnt),
		.push        (res_push)
	);

	// result buffer toward the receiver
	htw_out_fifo u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.cnt    (res_cnt),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for huffman_tree_walk_decoder, driving the cmd and result
// channels with random gaps and comparing every result item against a built-in tree walker
// depends on htw_pkg, htw_if (htw_cmd_if, htw_result_if) and the decoder rtl
`default_nettype none

module testbench;
	import htw_pkg::*;

	// mode 3 has no member in the package enum; the decoder drops it
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	localparam int MAX_WAIT     = 10;     // longest gap or stall per item
	localparam int DRAIN_CYCLES = 8;      // margin after the last expected result
	localparam int HOLD_CYCLES  = 200;    // long receiver hold-off, well past buffer depth
	localparam int PHASE_ITEMS  = 80;     // counted random items per root setting
	localparam int NUM_PHASES   = 5;

	typedef struct {
		logic [1:0] mode;
		idx_t       node_index;
		idx_t       left_child;
		idx_t       right_child;
		sym_t       leaf_symbol;
		logic       code_bit;
	} cmd_item_t;

	typedef struct {
		bit        is_cfg;    // row writes the root index, value in item.node_index
		cmd_item_t item;
		bit        typed;     // expectation typed in below, not taken from the walker
		result_t   want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	idx_t cfg_wr_data;

	htw_cmd_if    cmd_ch ();
	htw_result_if res_ch ();

	huffman_tree_walk_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.result      (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// walker state: our own copy of the tree, the walk position and the root register
	node_t tree_mem [TREE_NODES];
	bit    loaded   [TREE_NODES];
	idx_t  walk_node;
	bit    walk_at_root;
	idx_t  root_reg;

	result_t  sym_expect_q [$];
	dir_row_t dir_tab [$];

	int mismatch_count = 0;
	int n_items        = 0;
	int n_bits         = 0;
	int n_symbols      = 0;
	int n_walk_errors  = 0;
	int n_roots        = 0;
	int send_burst     = 0;
	int recv_burst     = 0;
	bit hold_off_req   = 1'b0;

	// wait for one item: a random gap of up to MAX_WAIT, with occasional stretches of back-to-back items
	function automatic int draw_wait(ref int burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			burst_left = $urandom_range(10, 40);
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// one item through the walker; a decode bit always makes exactly one result item
	task automatic walk_predict(input cmd_item_t it, output bit has_res, output result_t res);
		idx_t  here;
		idx_t  nxt;
		node_t nd;
		node_t ch;
		has_res = 1'b0;
		res     = '0;
		// every 9-bit index is inside the 512-entry store, so no write is ever dropped
		if (it.mode == MODE_WRITE) begin
			tree_mem[it.node_index] = '{left: it.left_child, right: it.right_child,
				sym: it.leaf_symbol};
			loaded[it.node_index] = 1'b1;
		end else if (it.mode == MODE_RESTART) begin
			walk_at_root = 1'b1;
			walk_node    = root_reg;
		end else if (it.mode == MODE_DECODE) begin
			has_res = 1'b1;
			// at the root the register is read as it is now, not as it was at restart
			here = walk_at_root ? root_reg : walk_node;
			nd   = tree_mem[here];
			if (nd.sym != '0) begin
				// bit applied while standing on a leaf: flag it, the walk does not move
				res.walk_error = 1'b1;
			end else begin
				nxt = it.code_bit ? nd.right : nd.left;
				ch  = tree_mem[nxt];
				if (ch.sym != '0) begin
					res.symbol_valid = 1'b1;
					res.symbol       = ch.sym;
					walk_at_root     = 1'b1;
					walk_node        = root_reg;
				end else begin
					walk_node    = nxt;
					walk_at_root = 1'b0;
				end
			end
		end
	endtask

	function automatic dir_row_t mk_row(int unsigned is_cfg, logic [1:0] mode,
		int unsigned idx, int unsigned lc, int unsigned rc, int unsigned sym,
		int unsigned b, int unsigned typed, int unsigned sv, int unsigned s,
		int unsigned e);
		dir_row_t r;
		r.is_cfg                = 1'(is_cfg);
		r.item.mode             = mode;
		r.item.node_index       = idx_t'(idx);
		r.item.left_child       = idx_t'(lc);
		r.item.right_child      = idx_t'(rc);
		r.item.leaf_symbol      = sym_t'(sym);
		r.item.code_bit         = 1'(b);
		r.typed                 = 1'(typed);
		r.want.symbol_valid     = 1'(sv);
		r.want.symbol           = sym_t'(s);
		r.want.walk_error       = 1'(e);
		return r;
	endfunction

	// write item for one node: a leaf gets a nonzero symbol, an internal node symbol 0
	function automatic cmd_item_t node_write(idx_t at, bit leaf);
		cmd_item_t it;
		it.mode        = MODE_WRITE;
		it.node_index  = at;
		it.left_child  = idx_t'($urandom_range(0, TREE_NODES - 1));
		it.right_child = idx_t'($urandom_range(0, TREE_NODES - 1));
		it.leaf_symbol = leaf ? sym_t'($urandom_range(1, 255)) : '0;
		it.code_bit    = 1'($urandom_range(0, 1));
		return it;
	endfunction

	// next random item; mostly decode bits that follow the loaded tree, with the
	// missing nodes written on the way so that no unloaded entry is ever read
	function automatic cmd_item_t next_walk_item();
		cmd_item_t   it;
		idx_t        here;
		idx_t        nxt;
		int unsigned pick;
		bit          b;
		it.mode        = MODE_DECODE;
		it.node_index  = idx_t'($urandom_range(0, TREE_NODES - 1));
		it.left_child  = idx_t'($urandom_range(0, TREE_NODES - 1));
		it.right_child = idx_t'($urandom_range(0, TREE_NODES - 1));
		it.leaf_symbol = sym_t'($urandom_range(0, 255));
		it.code_bit    = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		here = walk_at_root ? root_reg : walk_node;
		if (pick < 7) begin
			it.mode = MODE_RESTART;
		end else if (pick < 12) begin
			it.mode = MODE_IGNORED;
		end else if (pick < 24) begin
			// noise: any node rewritten, possibly the one the walk stands on
			it = node_write(idx_t'($urandom_range(0, TREE_NODES - 1)),
				1'($urandom_range(0, 1)));
		end else if (!loaded[here]) begin
			// mostly internal, sometimes a leaf, which gives a single-node tree at the root
			it = node_write(here, $urandom_range(0, 6) == 0);
		end else if (tree_mem[here].sym != '0) begin
			// standing on a leaf: either take the walk error or turn it back into a branch
			if ($urandom_range(0, 1))
				it = node_write(here, 1'b0);
		end else begin
			b   = 1'($urandom_range(0, 1));
			nxt = b ? tree_mem[here].right : tree_mem[here].left;
			if (!loaded[nxt]) begin
				b   = !b;
				nxt = b ? tree_mem[here].right : tree_mem[here].left;
			end
			if (!loaded[nxt])
				it = node_write(nxt, $urandom_range(0, 4) < 3);
			else
				it.code_bit = b;
		end
		return it;
	endfunction

	// offer one item after a random gap, hold it until taken, then run it through the walker
	task automatic send_cmd(input cmd_item_t it, input bit typed, input result_t want);
		int      gap;
		bit      has_res;
		result_t res;
		gap = draw_wait(send_burst);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.mode        <= it.mode;
		cmd_ch.node_index  <= it.node_index;
		cmd_ch.left_child  <= it.left_child;
		cmd_ch.right_child <= it.right_child;
		cmd_ch.leaf_symbol <= it.leaf_symbol;
		cmd_ch.code_bit    <= it.code_bit;
		do @(posedge clk); while (!cmd_ch.ready);
		walk_predict(it, has_res, res);
		n_items++;
		if (it.mode == MODE_DECODE)
			n_bits++;
		if (has_res)
			sym_expect_q.push_back(typed ? want : res);
	endtask

	// stop offering, let every expected result arrive and trailing writes settle
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (sym_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_root(input idx_t value);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		root_reg = value;
		n_roots++;
	endtask

	// receiver: random stall per result item, plus one long hold-off on request
	initial begin : result_sink
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = draw_wait(recv_burst);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// every taken result item is matched against the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (sym_expect_q.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result item, expected none, got valid %0b sym %02h err %0b",
					$time, res_ch.symbol_valid, res_ch.symbol, res_ch.walk_error);
			end else begin
				want = sym_expect_q.pop_front();
				if (want.symbol_valid)
					n_symbols++;
				if (want.walk_error)
					n_walk_errors++;
				if (res_ch.symbol_valid !== want.symbol_valid) begin
					mismatch_count++;
					$display("%0t: symbol_valid mismatch, expected %0b, got %0b",
						$time, want.symbol_valid, res_ch.symbol_valid);
				end
				if (res_ch.symbol !== want.symbol) begin
					mismatch_count++;
					$display("%0t: symbol mismatch, expected %02h, got %02h",
						$time, want.symbol, res_ch.symbol);
				end
				if (res_ch.walk_error !== want.walk_error) begin
					mismatch_count++;
					$display("%0t: walk_error mismatch, expected %0b, got %0b",
						$time, want.walk_error, res_ch.walk_error);
				end
			end
		end
	end

	initial begin : watchdog
		#2000000;
		$display("timeout: run did not complete, %0d results still outstanding",
			sym_expect_q.size());
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int        count;
		idx_t      new_root;
		cmd_item_t it;
		result_t   none;

		none = '0;
		arst_n             <= 1'b0;
		cfg_wr_en          <= 1'b0;
		cfg_wr_data        <= '0;
		cmd_ch.valid       <= 1'b0;
		cmd_ch.mode        <= MODE_WRITE;
		cmd_ch.node_index  <= '0;
		cmd_ch.left_child  <= '0;
		cmd_ch.right_child <= '0;
		cmd_ch.leaf_symbol <= '0;
		cmd_ch.code_bit    <= 1'b0;

		// walker reset state; the store itself is undefined until loaded
		foreach (tree_mem[i]) begin
			tree_mem[i] = '0;
			loaded[i]   = 1'b0;
		end
		walk_node    = '0;
		walk_at_root = 1'b1;
		root_reg     = '0;

		// directed table, root at its reset value 0 to begin with
		// small tree: 0 -> (1 leaf ff, 2), 2 -> (3 leaf 41, 511 leaf 01)
		dir_tab.push_back(mk_row(0, MODE_WRITE,   0,   1,   2,   'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_WRITE,   1,   511, 511, 'hff, 1, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_WRITE,   2,   3,   511, 'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_WRITE,   511, 0,   0,   'h01, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_WRITE,   3,   0,   0,   'h41, 1, 0, 0, 0,    0));
		// one-bit code straight after loading, then a two-bit code with unused fields at max
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 0, 1, 1, 'hff, 0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  511, 511, 511, 'hff, 1, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 1, 1, 'h01, 0));
		// restart in mid-code drops the partial walk
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_RESTART, 0,   0,   0,   'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 0, 0, 0, 0,    0));
		// unused mode with every field at its top must change nothing
		dir_tab.push_back(mk_row(0, MODE_IGNORED, 511, 511, 511, 'hff, 1, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 0, 1, 1, 'h41, 0));
		// stand on node 2, then rewrite it as a leaf under the walk: bits now hit a leaf
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_WRITE,   2,   0,   0,   'h80, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 0, 1, 0, 0,    1));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 1, 0, 0,    1));
		dir_tab.push_back(mk_row(0, MODE_RESTART, 0,   0,   0,   'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 1, 1, 'h80, 0));
		// single-node tree: root at the leaf 511, every bit is a walk error
		dir_tab.push_back(mk_row(1, MODE_WRITE,   511, 0,   0,   'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 0, 1, 0, 0,    1));
		dir_tab.push_back(mk_row(0, MODE_RESTART, 0,   0,   0,   'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 1, 0, 0,    1));
		// turn the root into a branch again and decode from it
		dir_tab.push_back(mk_row(0, MODE_WRITE,   511, 1,   3,   'h00, 0, 0, 0, 0,    0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 1, 1, 1, 'h41, 0));
		dir_tab.push_back(mk_row(0, MODE_DECODE,  0,   0,   0,   'h00, 0, 0, 0, 0,    0));
		// all-zero write: node 0 becomes a branch pointing at itself
		dir_tab.push_back(mk_row(0, MODE_WRITE,   0,   0,   0,   'h00, 0, 0, 0, 0,    0));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_root(dir_tab[i].item.node_index);
			else
				send_cmd(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
		end

		// random phases, one root setting each, the extremes 511 and 0 in phases 0 and 2
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       new_root = idx_t'(TREE_NODES - 1);
				2:       new_root = '0;
				default: new_root = idx_t'($urandom_range(0, TREE_NODES - 1));
			endcase
			write_root(new_root);
			count = 0;
			while (count < PHASE_ITEMS) begin
				// receiver goes quiet for a long stretch while items keep coming
				if (ph == 1 && count == 20)
					hold_off_req = 1'b1;
				// sender stops until the pipeline has fully drained
				if (ph == 3 && count == 45)
					wait_idle();
				it = next_walk_item();
				send_cmd(it, 1'b0, none);
				if (it.mode != MODE_IGNORED)
					count++;
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items (%0d code bits) over %0d root settings",
			n_items, n_bits, n_roots);
		$display("checked %0d decoded symbols and %0d walk errors", n_symbols, n_walk_errors);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/htw_pkg.sv
rtl/core/htw_if.sv
rtl/core/htw_node_store.sv
rtl/core/htw_walk_ctrl.sv
rtl/core/htw_out_fifo.sv
rtl/core/huffman_tree_walk_decoder.sv
tb/testbench.sv
